### design/phfm_pkg.sv
// Shared types and constants for the packet header filter.
package phfm_pkg;

   localparam int MaxLengthsDefault = 4;
   localparam int CountBitsDefault  = 16;

   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 64;
   localparam int LengthBits   = 16;

   // Byte offsets of the IPv4 addresses from the start of the layer 3 header.
   localparam int SrcIpOffset = 12;
   localparam int DstIpOffset = 16;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_FILTER_MASK   = 3'd0,
      CSR_WANT_SRC_IP   = 3'd1,
      CSR_WANT_DST_IP   = 3'd2,
      CSR_WANT_PORTS    = 3'd3,
      CSR_PAYLOAD_PLACE = 3'd4,
      CSR_PAYLOAD_BYTE  = 3'd5,
      CSR_LENGTH_COUNT  = 3'd6,
      CSR_LENGTH_LIST   = 3'd7
   } csr_index_type;

   // Bit positions in filter_mask.
   localparam int MaskLength  = 0;
   localparam int MaskSrcIp   = 1;
   localparam int MaskDstIp   = 2;
   localparam int MaskSrcPort = 3;
   localparam int MaskDstPort = 4;
   localparam int MaskPayload = 5;

   typedef struct packed {
      logic                  matched;
      logic [LengthBits-1:0] packet_length;
   } result_type;

endpackage

### design/packet_header_filter_match.sv
// Top level of the byte-serial IPv4 address and port packet filter.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | pkt_byte, first/last_byte, offsets
//   rsp     | out       | rsp_valid/rsp_stall | matched, packet_length
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// Each byte beat is registered, then processed by the capture and compare logic,
// so one byte per cycle is sustained while req_stall is low; a finished result is
// registered in a two-entry result buffer that lets bytes keep flowing while a
// result waits; req_stall rises only when a last byte finds that buffer full.
// Reset is synchronous and clears the configuration, the counters and the captures.
module packet_header_filter_match
   #(
      parameter int MAX_LENGTHS = phfm_pkg::MaxLengthsDefault,
      parameter int COUNT_BITS  = phfm_pkg::CountBitsDefault
   )
   (
      input  logic                               clock,
      input  logic                               reset,
      input  logic                               req_valid,
      output logic                               req_stall,
      input  logic [7:0]                         req_pkt_byte,
      input  logic                               req_first_byte,
      input  logic                               req_last_byte,
      input  logic [phfm_pkg::LengthBits-1:0]    req_net_offset,
      input  logic [phfm_pkg::LengthBits-1:0]    req_trans_offset,
      output logic                               rsp_valid,
      input  logic                               rsp_stall,
      output logic                               rsp_matched,
      output logic [phfm_pkg::LengthBits-1:0]    rsp_packet_length,
      input  logic                               csr_we,
      input  logic [phfm_pkg::CsrIndexBits-1:0]  csr_index,
      input  logic [phfm_pkg::CsrDataBits-1:0]   csr_wdata
   );

   import phfm_pkg::*;

   // Width wide enough for positions, header offsets plus constants and the payload end.
   localparam int PW = ((COUNT_BITS > LengthBits + 2) ? COUNT_BITS : LengthBits + 2) + 1;
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   // Configuration registers.
   logic [5:0]                      filter_mask_ff;
   logic [31:0]                     want_src_ip_ff;
   logic [31:0]                     want_dst_ip_ff;
   logic [31:0]                     want_ports_ff;
   logic [31:0]                     payload_place_ff;
   logic [7:0]                      payload_byte_ff;
   logic [2:0]                      length_count_ff;
   logic [MAX_LENGTHS*LengthBits-1:0] length_list_ff;

   // Input register.
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_first_ff;
   logic                  in_last_ff;
   logic [LengthBits-1:0] in_net_ff;
   logic [LengthBits-1:0] in_trans_ff;

   // Per-packet state.
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LengthBits-1:0] net_base_ff, net_base_in;
   logic [LengthBits-1:0] trans_base_ff, trans_base_in;
   logic [31:0]           seen_src_ip_ff, seen_src_ip_in;
   logic [31:0]           seen_dst_ip_ff, seen_dst_ip_in;
   logic [31:0]           seen_ports_ff, seen_ports_in;
   logic [7:0]            seen_payload_ff, seen_payload_in;

   // Result buffer: head register drives the ports, skid register behind it.
   logic       head_valid_ff;
   result_type head_ff;
   logic       skid_valid_ff;
   result_type skid_ff;

   logic                  accept;
   logic                  work;
   logic                  push;
   logic                  pop;
   result_type            result;
   logic [COUNT_BITS-1:0] pos;
   logic [PW-1:0]         pos_w;
   logic [PW-1:0]         len_w;
   logic [PW-1:0]         pl_index;
   logic [PW-1:0]         pl_end;
   logic [31:0]           cur_src_ip;
   logic [31:0]           cur_dst_ip;
   logic [31:0]           cur_ports;
   logic [7:0]            cur_payload;
   logic                  can_capture;
   logic                  length_hit;
   logic [5:0]            test_pass;

   // Places byte b into a big-endian word whose first byte sits at position base.
   function automatic logic [31:0] put_be(input logic [31:0] word, input logic [PW-1:0] p,
                                          input logic [PW-1:0] base, input logic [7:0] b);
      logic [PW-1:0] d;
      logic [31:0]   r;
      d = p - base;
      r = word;
      if (p >= base && d < PW'(4)) begin
         unique case (d[1:0])
            2'd0:    r[31:24] = b;
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8]  = b;
            default: r[7:0]   = b;
         endcase
      end
      return r;
   endfunction

   // A byte can move into the work stage unless it is a last byte and the buffer is full.
   assign work      = in_valid_ff && !(in_last_ff && skid_valid_ff);
   assign req_stall = in_valid_ff && !work;
   assign accept    = req_valid && !req_stall;
   assign push      = work && in_last_ff;
   assign pop       = head_valid_ff && !rsp_stall;

   always_comb begin
      net_base_in   = in_first_ff ? in_net_ff : net_base_ff;
      trans_base_in = in_first_ff ? in_trans_ff : trans_base_ff;
      pos           = in_first_ff ? '0 : count_ff;
      cur_src_ip    = in_first_ff ? '0 : seen_src_ip_ff;
      cur_dst_ip    = in_first_ff ? '0 : seen_dst_ip_ff;
      cur_ports     = in_first_ff ? '0 : seen_ports_ff;
      cur_payload   = in_first_ff ? '0 : seen_payload_ff;

      pos_w       = PW'(pos);
      pl_index    = PW'(trans_base_in) + PW'(payload_place_ff[31:16]);
      can_capture = (pos != CountMax);

      seen_src_ip_in  = cur_src_ip;
      seen_dst_ip_in  = cur_dst_ip;
      seen_ports_in   = cur_ports;
      seen_payload_in = cur_payload;
      count_in        = pos;
      if (can_capture) begin
         seen_src_ip_in = put_be(cur_src_ip, pos_w, PW'(net_base_in) + PW'(SrcIpOffset),
                                 in_byte_ff);
         seen_dst_ip_in = put_be(cur_dst_ip, pos_w, PW'(net_base_in) + PW'(DstIpOffset),
                                 in_byte_ff);
         seen_ports_in  = put_be(cur_ports, pos_w, PW'(trans_base_in), in_byte_ff);
         if (pos_w == pl_index) begin
            seen_payload_in = in_byte_ff;
         end
         count_in = pos + COUNT_BITS'(1);
      end
   end

   // Tests evaluated on the state as it stands after the current byte.
   always_comb begin
      len_w      = PW'(count_in);
      pl_end     = pl_index + PW'(payload_place_ff[15:0]);
      length_hit = 1'b0;
      for (int i = 0; i < MAX_LENGTHS; i++) begin
         if (3'(i) < length_count_ff
             && PW'(length_list_ff[i*LengthBits +: LengthBits]) == len_w) begin
            length_hit = 1'b1;
         end
      end
      test_pass[MaskLength]  = length_hit;
      test_pass[MaskSrcIp]   = (seen_src_ip_in == want_src_ip_ff);
      test_pass[MaskDstIp]   = (seen_dst_ip_in == want_dst_ip_ff);
      test_pass[MaskSrcPort] = (seen_ports_in[31:16] == want_ports_ff[31:16]);
      test_pass[MaskDstPort] = (seen_ports_in[15:0] == want_ports_ff[15:0]);
      test_pass[MaskPayload] = (pl_end < len_w) && (seen_payload_in == payload_byte_ff);

      result.matched       = &(test_pass | ~filter_mask_ff);
      result.packet_length = len_w[LengthBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mask_ff   <= '0;
         want_src_ip_ff   <= '0;
         want_dst_ip_ff   <= '0;
         want_ports_ff    <= '0;
         payload_place_ff <= '0;
         payload_byte_ff  <= '0;
         length_count_ff  <= '0;
         length_list_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FILTER_MASK:   filter_mask_ff   <= csr_wdata[5:0];
            CSR_WANT_SRC_IP:   want_src_ip_ff   <= csr_wdata[31:0];
            CSR_WANT_DST_IP:   want_dst_ip_ff   <= csr_wdata[31:0];
            CSR_WANT_PORTS:    want_ports_ff    <= csr_wdata[31:0];
            CSR_PAYLOAD_PLACE: payload_place_ff <= csr_wdata[31:0];
            CSR_PAYLOAD_BYTE:  payload_byte_ff  <= csr_wdata[7:0];
            CSR_LENGTH_COUNT:  length_count_ff  <= csr_wdata[2:0];
            default:           length_list_ff   <= csr_wdata[MAX_LENGTHS*LengthBits-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (work) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_pkt_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
         in_net_ff   <= req_net_offset;
         in_trans_ff <= req_trans_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         net_base_ff     <= '0;
         trans_base_ff   <= '0;
         seen_src_ip_ff  <= '0;
         seen_dst_ip_ff  <= '0;
         seen_ports_ff   <= '0;
         seen_payload_ff <= '0;
      end else if (work) begin
         net_base_ff   <= net_base_in;
         trans_base_ff <= trans_base_in;
         // The last byte of a packet leaves the counter and captures cleared.
         if (in_last_ff) begin
            count_ff        <= '0;
            seen_src_ip_ff  <= '0;
            seen_dst_ip_ff  <= '0;
            seen_ports_ff   <= '0;
            seen_payload_ff <= '0;
         end else begin
            count_ff        <= count_in;
            seen_src_ip_ff  <= seen_src_ip_in;
            seen_dst_ip_ff  <= seen_dst_ip_in;
            seen_ports_ff   <= seen_ports_in;
            seen_payload_ff <= seen_payload_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            head_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
            if (push) begin
               skid_ff <= result;
            end
         end else if (push) begin
            head_ff <= result;
         end
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid         = head_valid_ff;
   assign rsp_matched       = head_ff.matched;
   assign rsp_packet_length = head_ff.packet_length;

endmodule

### dv/tb_packet_header_filter_match.sv
// Self-checking testbench for the byte-serial IPv4 packet header filter.
module tb_packet_header_filter_match;
   timeunit 1ns;
   timeprecision 1ps;

   import phfm_pkg::*;

   localparam int CountMax      = 2**CountBitsDefault - 1;
   localparam int SettleCycles  = 8;
   localparam int HoldCycles    = 400;
   localparam int WatchdogLimit = 3000;
   localparam int PrintLimit    = 40;

   typedef struct {
      logic [7:0]            octet;
      logic                  first_flag;
      logic                  last_flag;
      logic [LengthBits-1:0] net_off;
      logic [LengthBits-1:0] trans_off;
   } filter_beat_type;

   typedef struct {
      logic [5:0]  mask;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] ports;
      logic [31:0] place;
      logic [7:0]  pay;
      logic [2:0]  lcount;
      logic [63:0] llist;
   } filter_setting_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_pkt_byte = '0;
   logic                    req_first_byte = 1'b0;
   logic                    req_last_byte = 1'b0;
   logic [LengthBits-1:0]   req_net_offset = '0;
   logic [LengthBits-1:0]   req_trans_offset = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_matched;
   logic [LengthBits-1:0]   rsp_packet_length;
   logic                    csr_we = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0]  csr_wdata = '0;

   filter_beat_type    byte_stim_q[$];
   filter_beat_type    beat_on_bus;
   result_type         expected_verdicts[$];
   result_type         verdict_due;
   filter_setting_type active_setting = '{default: '0};

   // Our own copy of the filter state.
   int unsigned     bytes_in_packet = 0;
   int unsigned     net_at = 0;
   int unsigned     trans_at = 0;
   logic [31:0]     got_src = '0;
   logic [31:0]     got_dst = '0;
   logic [31:0]     got_ports = '0;
   logic [7:0]      got_payload = '0;

   int sender_idle_pct = 21;
   int receiver_idle_pct = 59;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches_seen = 0;
   int verdicts_checked = 0;
   int matches_seen = 0;
   int bytes_taken = 0;
   int settings_written = 0;
   int queued_bytes = 0;
   int queued_verdicts = 0;

   packet_header_filter_match u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pkt_byte      (req_pkt_byte),
      .req_first_byte    (req_first_byte),
      .req_last_byte     (req_last_byte),
      .req_net_offset    (req_net_offset),
      .req_trans_offset  (req_trans_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_matched       (rsp_matched),
      .rsp_packet_length (rsp_packet_length),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      if (mismatches_seen < PrintLimit) begin
         $display("ERROR at %0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
      end
      mismatches_seen++;
   endtask

   function automatic logic [31:0] place_be(logic [31:0] word, int unsigned pos,
                                            int unsigned base, logic [7:0] octet);
      int unsigned shift;
      if (pos >= base && pos - base < 4) begin
         shift = 24 - 8 * (pos - base);
         word[shift +: 8] = octet;
      end
      return word;
   endfunction

   function automatic bit length_listed(int unsigned len);
      int unsigned entries;
      entries = (active_setting.lcount > MaxLengthsDefault) ? MaxLengthsDefault
                                                            : active_setting.lcount;
      for (int i = 0; i < entries; i++) begin
         if (active_setting.llist[16*i +: 16] == len) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the filter state by one byte and queues a verdict on a last byte.
   task automatic predict_filter_byte(filter_beat_type b);
      int unsigned pos;
      int unsigned pay_index;
      int unsigned pay_end;
      logic [5:0]  m;
      result_type  verdict;
      if (b.first_flag) begin
         bytes_in_packet = 0;
         net_at = b.net_off;
         trans_at = b.trans_off;
         got_src = '0;
         got_dst = '0;
         got_ports = '0;
         got_payload = '0;
      end
      pos = bytes_in_packet;
      pay_index = trans_at + active_setting.place[31:16];
      // Once the count has saturated, further bytes are not captured.
      if (pos < CountMax) begin
         got_src = place_be(got_src, pos, net_at + SrcIpOffset, b.octet);
         got_dst = place_be(got_dst, pos, net_at + DstIpOffset, b.octet);
         got_ports = place_be(got_ports, pos, trans_at, b.octet);
         if (pos == pay_index) got_payload = b.octet;
         bytes_in_packet = pos + 1;
      end
      if (b.last_flag) begin
         m = active_setting.mask;
         pay_end = pay_index + active_setting.place[15:0];
         verdict.packet_length = bytes_in_packet[LengthBits-1:0];
         verdict.matched = 1'b1;
         if (m != '0) begin
            if (m[MaskLength] && !length_listed(bytes_in_packet)) verdict.matched = 1'b0;
            if (m[MaskSrcIp] && got_src != active_setting.src) verdict.matched = 1'b0;
            if (m[MaskDstIp] && got_dst != active_setting.dst) verdict.matched = 1'b0;
            if (m[MaskSrcPort] && got_ports[31:16] != active_setting.ports[31:16])
               verdict.matched = 1'b0;
            if (m[MaskDstPort] && got_ports[15:0] != active_setting.ports[15:0])
               verdict.matched = 1'b0;
            if (m[MaskPayload] && (pay_end >= bytes_in_packet ||
                                   got_payload != active_setting.pay))
               verdict.matched = 1'b0;
         end
         expected_verdicts = {expected_verdicts, verdict};
         bytes_in_packet = 0;
         got_src = '0;
         got_dst = '0;
         got_ports = '0;
         got_payload = '0;
      end
   endtask

   // Byte sender: holds a beat until it is taken, then may idle before the next.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_filter_byte(beat_on_bus);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_stim_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               beat_on_bus = byte_stim_q.pop_front();
               req_valid <= 1'b1;
               req_pkt_byte <= beat_on_bus.octet;
               req_first_byte <= beat_on_bus.first_flag;
               req_last_byte <= beat_on_bus.last_flag;
               req_net_offset <= beat_on_bus.net_off;
               req_trans_offset <= beat_on_bus.trans_off;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Verdict receiver and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("verdict with none outstanding", rsp_packet_length, 0);
            end else begin
               verdict_due = expected_verdicts.pop_front();
               if (rsp_matched !== verdict_due.matched)
                  report_mismatch("matched", rsp_matched, verdict_due.matched);
               if (rsp_packet_length !== verdict_due.packet_length)
                  report_mismatch("packet_length", rsp_packet_length,
                                  verdict_due.packet_length);
               verdicts_checked++;
               if (verdict_due.matched) matches_seen++;
            end
         end
         if (hold_req) begin
            hold_left = HoldCycles;
            hold_req = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && (byte_stim_q.size() != 0 || req_valid || expected_verdicts.size() != 0)
          && !(req_valid && !req_stall) && !(rsp_valid && !rsp_stall)) begin
         quiet_cycles++;
      end else begin
         quiet_cycles = 0;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Watchdog: no beat moved for %0d cycles, %0d verdicts outstanding.",
                  quiet_cycles, expected_verdicts.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_quiet();
      while (byte_stim_q.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
      // Bytes that end no packet may still be in the pipeline.
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_setting(filter_setting_type s);
      csr_index_type idx;
      for (int i = 0; i < 2**CsrIndexBits; i++) begin
         idx = csr_index_type'(i);
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_FILTER_MASK:   csr_wdata <= 64'(s.mask);
            CSR_WANT_SRC_IP:   csr_wdata <= 64'(s.src);
            CSR_WANT_DST_IP:   csr_wdata <= 64'(s.dst);
            CSR_WANT_PORTS:    csr_wdata <= 64'(s.ports);
            CSR_PAYLOAD_PLACE: csr_wdata <= 64'(s.place);
            CSR_PAYLOAD_BYTE:  csr_wdata <= 64'(s.pay);
            CSR_LENGTH_COUNT:  csr_wdata <= 64'(s.lcount);
            CSR_LENGTH_LIST:   csr_wdata <= s.llist;
         endcase
      end
      @(posedge clock);
      csr_we <= 1'b0;
      active_setting = s;
      settings_written++;
   endtask

   // Builds one packet whose header fields follow the active setting; each field
   // is replaced by a random value with probability err_pct.
   task automatic queue_packet(int len, int noff, int toff, bit with_first, bit with_last,
                               int err_pct);
      logic [7:0]      data [];
      filter_beat_type beat;
      logic [31:0]     src_v;
      logic [31:0]     dst_v;
      logic [31:0]     port_v;
      logic [7:0]      pay_v;
      int              pay_at;
      data = new[len];
      foreach (data[i]) data[i] = 8'($urandom);
      src_v = ($urandom_range(99) < err_pct) ? $urandom : active_setting.src;
      dst_v = ($urandom_range(99) < err_pct) ? $urandom : active_setting.dst;
      port_v = ($urandom_range(99) < err_pct) ? $urandom : active_setting.ports;
      pay_v = ($urandom_range(99) < err_pct) ? 8'($urandom) : active_setting.pay;
      for (int k = 0; k < 4; k++) begin
         if (noff + SrcIpOffset + k < len) data[noff + SrcIpOffset + k] = src_v[31-8*k -: 8];
         if (noff + DstIpOffset + k < len) data[noff + DstIpOffset + k] = dst_v[31-8*k -: 8];
         if (toff + k < len) data[toff + k] = port_v[31-8*k -: 8];
      end
      pay_at = toff + active_setting.place[31:16];
      if (pay_at < len) data[pay_at] = pay_v;
      foreach (data[i]) begin
         beat.octet = data[i];
         beat.first_flag = with_first && (i == 0);
         beat.last_flag = with_last && (i == len - 1);
         beat.net_off = (i == 0) ? noff[15:0] : 16'($urandom);
         beat.trans_off = (i == 0) ? toff[15:0] : 16'($urandom);
         byte_stim_q = {byte_stim_q, beat};
      end
      queued_bytes += len;
      if (with_last) queued_verdicts++;
   endtask

   task automatic queue_random_traffic(int byte_goal, int verdict_goal);
      int shape;
      int noff;
      int toff;
      int len;
      queued_bytes = 0;
      queued_verdicts = 0;
      while (queued_bytes < byte_goal || queued_verdicts < verdict_goal) begin
         shape = $urandom_range(9);
         noff = $urandom_range(0, 24);
         toff = noff + 20 + (($urandom_range(3) == 0) ? $urandom_range(0, 16) : 0);
         len = toff + 4 + $urandom_range(0, 40);
         // Half of the time aim at a length from the accepted list.
         if (active_setting.lcount != 0 && $urandom_range(1) == 1) begin
            len = active_setting.llist[16*$urandom_range(3) +: 16];
            if (len == 0 || len > 200) len = toff + 4 + $urandom_range(0, 40);
         end
         case (shape)
            0, 1, 2, 3, 4, 5: queue_packet(len, noff, toff, 1'b1, 1'b1, 8);
            6, 7:             queue_packet($urandom_range(1, 12), noff, toff, 1'b1, 1'b1, 8);
            8:                queue_packet(len, noff, toff, 1'b0, 1'b1, 8);
            default: begin
               if ($urandom_range(1) == 1)
                  queue_packet($urandom_range(1, 3), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(1),
                               $urandom_range(1), 100);
               else
                  queue_packet($urandom_range(5, 30), noff, toff, 1'b1, 1'b0, 8);
            end
         endcase
      end
   endtask

   task automatic run_phase(filter_setting_type s, int send_pct, int recv_pct, bit hold_out);
      wait_quiet();
      write_setting(s);
      @(negedge clock);
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      queue_random_traffic(100, 10);
      if (hold_out) hold_req = 1'b1;
   endtask

   function automatic filter_setting_type random_setting();
      filter_setting_type s;
      s.mask = 6'($urandom);
      s.src = $urandom;
      s.dst = $urandom;
      s.ports = $urandom;
      s.place = {16'($urandom_range(0, 8)), 16'($urandom_range(0, 8))};
      s.pay = 8'($urandom);
      s.lcount = 3'($urandom);
      s.llist = {16'($urandom_range(20, 70)), 16'($urandom_range(20, 70)),
                 16'($urandom_range(20, 70)), 16'($urandom_range(20, 70))};
      return s;
   endfunction

   initial begin
      filter_setting_type s;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset setting lets everything pass: a one-byte packet, then a byte
      // with no first marker that carries on with the kept offsets.
      @(negedge clock);
      queue_packet(1, 0, 0, 1'b1, 1'b1, 0);
      queue_packet(1, 0, 0, 1'b0, 1'b1, 100);
      wait_quiet();

      s = '{default: '0};
      s.mask = '1;
      s.src = 32'hC0A8_0001;
      s.dst = 32'h0A00_0002;
      s.ports = 32'h1234_0050;
      s.place = 32'h0000_0001;
      s.pay = 8'h12;
      s.lcount = 3'd4;
      s.llist = {16'hFFFF, 16'd1, 16'd100, 16'd24};
      write_setting(s);
      @(negedge clock);
      queue_packet(24, 0, 20, 1'b1, 1'b1, 0);
      queue_packet(1, 0, 20, 1'b1, 1'b1, 0);
      wait_quiet();

      // Length test with an empty list rejects everything.
      s = '{default: '0};
      s.mask = 6'(1 << MaskLength);
      write_setting(s);
      @(negedge clock);
      queue_packet(1, 0, 0, 1'b1, 1'b1, 0);
      wait_quiet();

      // A count above the list size still looks at all four entries.
      s.lcount = 3'd7;
      s.llist = {16'd3, 16'd9, 16'd9, 16'd9};
      write_setting(s);
      @(negedge clock);
      queue_packet(3, 0, 0, 1'b1, 1'b1, 0);
      wait_quiet();

      // Headers past the end of a short packet read as zero.
      s = '{default: '0};
      s.mask = 6'((1 << MaskSrcIp) | (1 << MaskDstIp));
      write_setting(s);
      @(negedge clock);
      queue_packet(2, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 0);

      s = random_setting();
      s.mask = '1;
      s.lcount = 3'd4;
      run_phase(s, 21, 59, 1'b0);
      s.mask = '1;
      s.src = '1;
      s.dst = '1;
      s.ports = '1;
      s.place = '0;
      s.pay = '1;
      s.lcount = 3'd7;
      s.llist = {16'($urandom_range(20, 70)), 16'($urandom_range(20, 70)), 16'h0000, 16'hFFFF};
      run_phase(s, 21, 59, 1'b0);
      run_phase(random_setting(), 59, 21, 1'b0);
      s = '{default: '0};
      run_phase(s, 59, 21, 1'b0);
      run_phase(random_setting(), 0, 0, 1'b1);
      s = random_setting();
      s.mask[MaskPayload] = 1'b1;
      s.place = '1;
      run_phase(s, 0, 0, 1'b0);

      wait_quiet();
      if (expected_verdicts.size() != 0)
         report_mismatch("verdicts never delivered", 0, expected_verdicts.size());
      $display("Checked %0d verdicts (%0d matches) from %0d bytes under %0d filter settings,",
               verdicts_checked, matches_seen, bytes_taken, settings_written);
      $display("including short and unmarked packets and a %0d-cycle output hold-off.",
               HoldCycles);
      if (mismatches_seen == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
